[rtl/tps_pkg.sv]
package tps_pkg;

  // CORDIC length, 8..24
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int ANG_W  = 26;   // Q9.16 degrees
  localparam int RATE_W = 20;   // Q11.8 deg/s
  localparam int ACC_W  = 16;
  localparam int CR_W   = 32;   // CORDIC x/y width

  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_CENTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOW     = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_PRED,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DRV,
    ST_DSUM,
    ST_FIN
  } tps_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
    logic              pred;
    logic              diff;
    logic              mul;
    logic              sum;
    logic              drv;
    logic              dsum;
    logic              out;
  } tps_cmd_t;

  // arctan(2^-i) in Q9.16 degrees, rounded
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117305;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tilt_pd_servo_pwm.sv]
// Tilt servo: one IMU sample in, one servo compare value out.
// Input channel (in_valid / in_stall): accel_y, accel_z (shared scale) and
// rate_x (Q11.8 deg/s). The accel tilt atan2(y, z) comes from a vectoring
// CORDIC, one iteration per clock; the stored Q9.16 tilt is then blended
// (complementary filter), saturated, and fed to a PD drive that is clamped
// to [drive_low, drive_high].
// Output channel (out_valid / out_stall): drive_count, tilt_angle,
// was_clamped, held in an output register.
// Timing: an item is accepted only while the engine is idle. The engine
// then runs the CORDIC loop and the states PRED, DIFF, MUL, SUM, DRV, DSUM
// and FIN; the result is registered from FIN, and the next item can be
// taken in the cycle after that. The CORDIC loop makes up most of the run.
// A result waiting under out_stall does not block the next item; only the
// final write into a still-occupied output register waits for the transfer.
// Config writes (cfg_we / cfg_index / cfg_wdata) are registered, no
// read-back; write only while idle.
// Reset (rst_n, synchronous): config registers return to defaults, the
// filtered angle to zero degrees, and both channels go empty.
module tilt_pd_servo_pwm (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tps_pkg::ACC_W-1:0]      in_accel_y,
  input  logic signed [tps_pkg::ACC_W-1:0]      in_accel_z,
  input  logic signed [tps_pkg::RATE_W-1:0]     in_rate_x,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [15:0]                           out_drive_count,
  output logic signed [tps_pkg::ANG_W-1:0]      out_tilt_angle,
  output logic                                  out_was_clamped,
  input  logic                                  cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  tps_pkg::tps_cmd_t cmd;

  // sequencer: CORDIC count, blend and drive steps, output handshake
  tps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic, config registers, filter state and output register
  tps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_rate_x       (in_rate_x),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_drive_count (out_drive_count),
    .out_tilt_angle  (out_tilt_angle),
    .out_was_clamped (out_was_clamped)
  );

endmodule

[rtl/tps_ctrl.sv]
module tps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tps_pkg::tps_cmd_t cmd
);

  tps_pkg::tps_state_t              state_r, state_nxt;
  logic [tps_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tps_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    case (state_r)
      tps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = tps_pkg::ST_CORDIC;
        end
      end
      tps_pkg::ST_CORDIC: begin
        cmd.step = 1'b1;
        if (cnt_r == tps_pkg::STEP_W'(tps_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = tps_pkg::ST_PRED;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tps_pkg::ST_PRED: begin
        cmd.pred  = 1'b1;
        state_nxt = tps_pkg::ST_DIFF;
      end
      tps_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = tps_pkg::ST_MUL;
      end
      tps_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = tps_pkg::ST_SUM;
      end
      tps_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = tps_pkg::ST_DRV;
      end
      tps_pkg::ST_DRV: begin
        cmd.drv   = 1'b1;
        state_nxt = tps_pkg::ST_DSUM;
      end
      tps_pkg::ST_DSUM: begin
        cmd.dsum  = 1'b1;
        state_nxt = tps_pkg::ST_FIN;
      end
      tps_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out   = 1'b1;
          state_nxt = tps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != tps_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/tps_dp.sv]
module tps_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tps_pkg::tps_cmd_t                     cmd,
  input  logic signed [tps_pkg::ACC_W-1:0]      in_accel_y,
  input  logic signed [tps_pkg::ACC_W-1:0]      in_accel_z,
  input  logic signed [tps_pkg::RATE_W-1:0]     in_rate_x,
  input  logic                                  cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic [15:0]                           out_drive_count,
  output logic signed [tps_pkg::ANG_W-1:0]      out_tilt_angle,
  output logic                                  out_was_clamped
);

  // configuration
  logic [16:0]        bw_r;
  logic [15:0]        per_r;
  logic signed [15:0] kp_r;
  logic signed [15:0] kd_r;
  logic [15:0]        ctr_r;
  logic [15:0]        hi_r;
  logic [15:0]        lo_r;

  // filter state
  logic signed [tps_pkg::ANG_W-1:0] ang_r;

  // CORDIC
  logic signed [tps_pkg::CR_W-1:0]  cx_r, cy_r;
  logic signed [tps_pkg::ANG_W-1:0] cz_r;
  logic                             zero_r;
  logic signed [tps_pkg::RATE_W-1:0] rate_r;

  // arithmetic pipeline
  logic signed [37:0] pred_r;
  logic signed [38:0] diff_r;
  logic signed [36:0] ph_r;
  logic signed [38:0] pl_r;
  logic signed [41:0] pa_r;
  logic signed [35:0] pr_r;
  logic signed [45:0] drv_r;

  // result register
  logic [15:0]                      cnt_r;
  logic signed [tps_pkg::ANG_W-1:0] oang_r;
  logic                             clamp_r;

  logic [16:0]                      alpha;
  logic signed [tps_pkg::ANG_W-1:0] acc;
  logic signed [tps_pkg::CR_W-1:0]  ax, ay, dx, dy;
  logic signed [tps_pkg::ANG_W-1:0] z0, atan_v;
  logic signed [36:0]               rp;
  logic signed [18:0]               dh;
  logic [19:0]                      dl;
  logic signed [56:0]               mix;
  logic signed [33:0]               raw;
  logic signed [tps_pkg::ANG_W-1:0] ang_sat;
  logic signed [45:0]               hi46, lo46;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= 17'd32768;
      per_r <= 16'd6554;
      kp_r  <= 16'sd3840;
      kd_r  <= 16'sd26;
      ctr_r <= 16'd1500;
      hi_r  <= 16'd2000;
      lo_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        tps_pkg::CFG_BLEND_WEIGHT:  bw_r  <= cfg_wdata;
        tps_pkg::CFG_SAMPLE_PERIOD: per_r <= cfg_wdata[15:0];
        tps_pkg::CFG_ANGLE_GAIN:    kp_r  <= cfg_wdata[15:0];
        tps_pkg::CFG_RATE_GAIN:     kd_r  <= cfg_wdata[15:0];
        tps_pkg::CFG_DRIVE_CENTER:  ctr_r <= cfg_wdata[15:0];
        tps_pkg::CFG_DRIVE_HIGH:    hi_r  <= cfg_wdata[15:0];
        tps_pkg::CFG_DRIVE_LOW:     lo_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign alpha = (bw_r > 17'd65536) ? 17'd65536 : bw_r;
  assign acc   = zero_r ? '0 : cz_r;

  // CORDIC load: scale by 2^14, fold the left half plane over
  assign ax = {{2{in_accel_z[15]}}, in_accel_z, 14'b0};
  assign ay = {{2{in_accel_y[15]}}, in_accel_y, 14'b0};
  assign z0 = !in_accel_z[15] ? '0 : (!in_accel_y[15] ? tps_pkg::DEG180 : -tps_pkg::DEG180);

  assign dx     = cy_r >>> cmd.idx;
  assign dy     = cx_r >>> cmd.idx;
  assign atan_v = $signed({4'b0, tps_pkg::atan_lut(5'(cmd.idx))});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= in_accel_z[15] ? -ax : ax;
      cy_r   <= in_accel_z[15] ? -ay : ay;
      cz_r   <= z0;
      zero_r <= (in_accel_y == '0) && (in_accel_z == '0);
      rate_r <= in_rate_x;
    end else if (cmd.step) begin
      if (!cy_r[tps_pkg::CR_W-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + atan_v;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - atan_v;
      end
    end
  end

  // blend: ang = floor(alpha * (pred - acc*2^8) / 2^24) + acc
  assign rp  = rate_r * $signed({1'b0, per_r});
  assign dh  = diff_r[38:20];
  assign dl  = diff_r[19:0];
  assign mix = (57'(ph_r) <<< 20) + 57'(pl_r);
  assign raw = 34'(mix >>> 24) + 34'(acc);

  always_comb begin
    if (raw > 34'sd33554431) begin
      ang_sat = 26'sd33554431;
    end else if (raw < -34'sd33554432) begin
      ang_sat = -26'sd33554432;
    end else begin
      ang_sat = raw[tps_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pred) pred_r <= (38'(ang_r) <<< 8) + 38'(rp);
    if (cmd.diff) diff_r <= 39'(pred_r) - (39'(acc) <<< 8);
    if (cmd.mul) begin
      ph_r <= $signed({1'b0, alpha}) * dh;
      pl_r <= $signed({1'b0, alpha}) * $signed({1'b0, dl});
    end
    if (cmd.drv) begin
      pa_r <= kp_r * ang_r;
      pr_r <= kd_r * rate_r;
    end
    if (cmd.dsum) begin
      drv_r <= $signed({6'b0, ctr_r, 24'b0}) + 46'(pa_r) + (46'(pr_r) <<< 8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0;
    end else if (cmd.sum) begin
      ang_r <= ang_sat;
    end
  end

  assign hi46 = $signed({6'b0, hi_r, 24'b0});
  assign lo46 = $signed({6'b0, lo_r, 24'b0});

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      oang_r <= ang_r;
      if (drv_r > hi46) begin
        cnt_r   <= hi_r;
        clamp_r <= 1'b1;
      end else if (drv_r < lo46) begin
        cnt_r   <= lo_r;
        clamp_r <= 1'b1;
      end else begin
        cnt_r   <= drv_r[39:24];
        clamp_r <= 1'b0;
      end
    end
  end

  assign out_drive_count = cnt_r;
  assign out_tilt_angle  = oang_r;
  assign out_was_clamped = clamp_r;

endmodule

[rtl/tps_chk.sv]
module tps_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [15:0]                           out_drive_count,
  input logic signed [tps_pkg::ANG_W-1:0]      out_tilt_angle,
  input logic                                  out_was_clamped
);

  // engine goes busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken but engine not busy");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

  // reset empties both channels
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not empty after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_count)
      && $stable(out_tilt_angle) && $stable(out_was_clamped))
    else $error("stalled result changed");

endmodule

bind tilt_pd_servo_pwm tps_chk u_chk (.*);
